// File: sv/tsm_pkg.sv
// ============================================================================
// Topic subscription matcher package
// Shared types and constants: transaction payloads, cell commands, cell chain.
// ============================================================================
package tsm_pkg;

	localparam int MAX_SUBS_DEF       = 16;
	localparam int MAX_FILTER_LEN_DEF = 64;

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef enum logic [1:0] {
		MODE_SUB   = 2'd0,
		MODE_PUB   = 2'd1,
		MODE_CLOSE = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		K_SUBSCRIBED = 3'd0,
		K_FULL       = 3'd1,
		K_TOO_LONG   = 3'd2,
		K_DELIVER    = 3'd3,
		K_PUB_DONE   = 3'd4,
		K_CLOSE_DONE = 3'd5
	} kind_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] conn_id;
		logic [7:0] char_code;
		logic       last_char;
		logic       empty_text;
	} tsm_in_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] target_conn;
		logic [4:0] removed_count;
		logic       final_result;
	} tsm_out_t;

	typedef enum logic [3:0] {
		OP_NONE       = 4'd0,
		OP_CLR        = 4'd1,
		OP_FEED       = 4'd2,
		OP_FIN        = 4'd3,
		OP_SUB_START  = 4'd4,
		OP_WRITE      = 4'd5,
		OP_COMMIT     = 4'd6,
		OP_CLOSE_MARK = 4'd7,
		OP_CLOSE_STEP = 4'd8,
		OP_SCAN       = 4'd9
	} cell_op_t;

	typedef struct packed {
		cell_op_t   op;
		logic [7:0] char_code;
		logic [7:0] conn_id;
		logic       scan_hit;
	} cell_cmd_t;

	// rippled from cell 0 upward
	typedef struct packed {
		logic       busy;
		logic       taken;
		logic       sel_hit;
		logic [7:0] sel_owner;
	} chain_t;

endpackage

// File: sv/tsm_ram.sv
// ============================================================================
// Generic single-port-write RAM
// One write port, one read port, registered read data.
// ============================================================================
module tsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// File: sv/tsm_cell.sv
// ============================================================================
// Subscription cell
// Holds one table entry, its filter text and its streaming matcher.
// ============================================================================
module tsm_cell #(
	parameter int MAX_SUBS       = 16,
	parameter int MAX_FILTER_LEN = 64,
	localparam int LW = $clog2(MAX_FILTER_LEN + 1),
	localparam int AW = $clog2(MAX_FILTER_LEN),
	localparam int RW = (MAX_SUBS > 1) ? $clog2(MAX_SUBS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tsm_pkg::cell_cmd_t cmd,
	input  logic [LW-1:0]      cmd_len,
	input  logic [RW-1:0]      cmd_rank,
	input  tsm_pkg::chain_t    chain_i,
	output tsm_pkg::chain_t    chain_o
);

	import tsm_pkg::*;

	typedef enum logic [2:0] {
		C_IDLE = 3'b001,
		C_READ = 3'b010,
		C_EVAL = 3'b100
	} cst_t;

	cst_t          st_q, st_d;
	logic          valid_q, valid_d, target_q, target_d, dying_q, dying_d;
	logic [7:0]    owner_q, owner_d, c_q, c_d;
	logic [LW-1:0] len_q, len_d, pos_q, pos_d, pos_inc;
	logic [RW-1:0] rank_q, rank_d;
	logic          dead_q, dead_d, acc_q, acc_d, plus_q, plus_d;
	logic          hit_q, hit_d, after_q, after_d, fin_q, fin_d;
	logic          wr_en, in_range, at_last, my_sel;
	logic [7:0]    rd_data;

	tsm_ram #(.WIDTH(8), .DEPTH(MAX_FILTER_LEN)) u_text (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cmd_len[AW-1:0]),
		.wr_data (cmd.char_code),
		.rd_addr (pos_q[AW-1:0]),
		.rd_data (rd_data)
	);

	assign pos_inc  = pos_q + LW'(1);
	assign in_range = pos_q < len_q;
	assign at_last  = pos_inc == len_q;

	always_comb begin
		st_d = st_q; valid_d = valid_q; target_d = target_q; dying_d = dying_q;
		owner_d = owner_q; c_d = c_q; len_d = len_q; pos_d = pos_q; rank_d = rank_q;
		dead_d = dead_q; acc_d = acc_q; plus_d = plus_q; hit_d = hit_q;
		after_d = after_q; fin_d = fin_q;
		wr_en = 1'b0;
		unique case (st_q)
			C_IDLE: begin
				unique case (cmd.op)
					OP_CLR: begin
						pos_d = '0; dead_d = 1'b0; acc_d = 1'b0; plus_d = 1'b0;
					end
					OP_FEED: begin
						c_d = cmd.char_code;
						fin_d = 1'b0;
						if (valid_q && !dead_q && !acc_q) begin
							if (plus_q) begin
								if (cmd.char_code == CH_SLASH) begin
									plus_d = 1'b0; pos_d = pos_inc; after_d = 1'b1;
									st_d = C_READ;
								end
							end else begin
								after_d = 1'b0;
								st_d = C_READ;
							end
						end
					end
					OP_FIN: begin
						fin_d = 1'b1;
						if (!valid_q || dead_q) begin
							hit_d = 1'b0;
						end else if (acc_q) begin
							hit_d = 1'b1;
						end else if (plus_q) begin
							plus_d = 1'b0; pos_d = pos_inc; after_d = 1'b1;
							st_d = C_READ;
						end else begin
							after_d = 1'b0;
							st_d = C_READ;
						end
					end
					OP_SUB_START: target_d = !valid_q && !chain_i.taken;
					OP_WRITE: wr_en = target_q;
					OP_COMMIT: begin
						if (valid_q) begin
							rank_d = rank_q + RW'(1);
						end
						if (target_q) begin
							valid_d = 1'b1; owner_d = cmd.conn_id; len_d = cmd_len;
							rank_d = '0; target_d = 1'b0;
						end
					end
					OP_CLOSE_MARK: begin
						dying_d = valid_q && owner_q == cmd.conn_id;
						if (valid_q && owner_q == cmd.conn_id) begin
							valid_d = 1'b0;
						end
					end
					OP_CLOSE_STEP: begin
						if (valid_q && cmd.scan_hit && rank_q > cmd_rank) begin
							rank_d = rank_q - RW'(1);
						end
					end
					default: ;
				endcase
			end
			C_READ: st_d = C_EVAL;
			C_EVAL: begin
				st_d = C_IDLE;
				after_d = 1'b0;
				if (after_q && in_range && rd_data == CH_SLASH) begin
					if (fin_q) hit_d = 1'b0;
					else pos_d = pos_inc;
				end else if (!in_range) begin
					if (fin_q) hit_d = 1'b1;
					else dead_d = 1'b1;
				end else if (rd_data == CH_HASH) begin
					if (fin_q) hit_d = at_last;
					else if (at_last) acc_d = 1'b1;
					else dead_d = 1'b1;
				end else if (rd_data == CH_PLUS) begin
					// a level wildcard: close it at once when the topic sits on a separator or has ended
					if (fin_q || c_q == CH_SLASH) begin
						pos_d = pos_inc; after_d = 1'b1; st_d = C_READ;
					end else begin
						plus_d = 1'b1;
					end
				end else if (!fin_q && rd_data == c_q) begin
					pos_d = pos_inc;
				end else if (fin_q) begin
					hit_d = 1'b0;
				end else begin
					dead_d = 1'b1;
				end
			end
			default: st_d = C_IDLE;
		endcase
	end

	always_comb begin
		my_sel = ((cmd.op == OP_SCAN) && valid_q && hit_q && rank_q == cmd_rank)
			|| ((cmd.op == OP_CLOSE_STEP) && dying_q && rank_q == cmd_rank);
		chain_o.busy      = chain_i.busy || (st_q != C_IDLE);
		chain_o.taken     = chain_i.taken || !valid_q;
		chain_o.sel_hit   = chain_i.sel_hit || my_sel;
		chain_o.sel_owner = my_sel ? owner_q : chain_i.sel_owner;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_IDLE; valid_q <= 1'b0; target_q <= 1'b0; dying_q <= 1'b0;
			pos_q <= '0; dead_q <= 1'b0; acc_q <= 1'b0; plus_q <= 1'b0;
			hit_q <= 1'b0; after_q <= 1'b0; fin_q <= 1'b0;
		end else begin
			st_q <= st_d; valid_q <= valid_d; target_q <= target_d; dying_q <= dying_d;
			pos_q <= pos_d; dead_q <= dead_d; acc_q <= acc_d; plus_q <= plus_d;
			hit_q <= hit_d; after_q <= after_d; fin_q <= fin_d;
		end
	end

	always_ff @(posedge clk) begin
		owner_q <= owner_d;
		c_q     <= c_d;
		len_q   <= len_d;
		rank_q  <= rank_d;
	end

endmodule

// File: sv/topic_subscription_matcher.sv
// ============================================================================
// Topic subscription matcher
// Table of topic-filter subscriptions held in a chain of cells; publish topics
// stream through every cell and matching subscribers are delivered newest first.
// ============================================================================
// A topic character waits for the slowest cell's RAM reads, including the
// walk past a '+' over filter characters. A topic's last character adds the
// finish walk, a scan over all MAX_SUBS ranks and the done marker; a close
// scans all ranks from the top down. Transactions are taken one at a time,
// stalled by a full output; a result may wait while the next enters.
// Reset is asynchronous and leaves the table empty.
module topic_subscription_matcher #(
	parameter int MAX_SUBS       = tsm_pkg::MAX_SUBS_DEF,
	parameter int MAX_FILTER_LEN = tsm_pkg::MAX_FILTER_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  tsm_pkg::tsm_in_t  item,
	output logic              result_valid,
	input  logic              result_ready,
	output tsm_pkg::tsm_out_t result
);

	import tsm_pkg::*;

	localparam int LW  = $clog2(MAX_FILTER_LEN + 1);
	localparam int LCW = $clog2(MAX_FILTER_LEN + 2);
	localparam int RW  = (MAX_SUBS > 1) ? $clog2(MAX_SUBS) : 1;
	localparam int CW  = $clog2(MAX_SUBS + 1);

	typedef enum logic [10:0] {
		S_IDLE       = 11'b00000000001,
		S_DECODE     = 11'b00000000010,
		S_SUB_CHAR   = 11'b00000000100,
		S_COMMIT     = 11'b00000001000,
		S_FEED_GO    = 11'b00000010000,
		S_FEED_WAIT  = 11'b00000100000,
		S_FIN_GO     = 11'b00001000000,
		S_FIN_WAIT   = 11'b00010000000,
		S_SCAN       = 11'b00100000000,
		S_CLOSE_SCAN = 11'b01000000000,
		S_EMIT       = 11'b10000000000
	} st_t;

	st_t            st_q, st_d;
	tsm_in_t        item_q, item_d;
	tsm_out_t       res_q, res_d, out_q, load_data;
	logic           out_valid_q, out_free, load;
	logic           run_active_q, run_active_d, run_pub_q, run_pub_d, full_q, full_d;
	logic [LCW-1:0] len_cnt_q, len_cnt_d, len_next;
	logic [LW-1:0]  commit_len_q, commit_len_d, cmd_len;
	logic [RW-1:0]  scan_rank_q, scan_rank_d, cmd_rank;
	logic [CW-1:0]  removed_q, removed_d;
	logic           is_pub, table_full, busy;
	cell_cmd_t      cmd;
	chain_t         chain [MAX_SUBS+1];

	function automatic tsm_out_t mk_res(kind_t k, logic [7:0] conn, logic [4:0] rem,
		logic fin);
		tsm_out_t r;
		r.kind          = k;
		r.target_conn   = conn;
		r.removed_count = rem;
		r.final_result  = fin;
		return r;
	endfunction

	// Cell chain: free-slot search, busy flag and rank selection ripple upward
	assign chain[0] = '0;

	for (genvar i = 0; i < MAX_SUBS; i++) begin : g_cell
		tsm_cell #(.MAX_SUBS(MAX_SUBS), .MAX_FILTER_LEN(MAX_FILTER_LEN)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.cmd_len  (cmd_len),
			.cmd_rank (cmd_rank),
			.chain_i  (chain[i]),
			.chain_o  (chain[i+1])
		);
	end

	assign busy       = chain[MAX_SUBS].busy;
	assign table_full = !chain[MAX_SUBS].taken;
	assign is_pub     = item_q.mode == MODE_PUB;
	assign out_free   = !out_valid_q || result_ready;
	assign item_ready = st_q == S_IDLE;
	assign len_next   = (len_cnt_q <= LCW'(MAX_FILTER_LEN)) ? len_cnt_q + LCW'(1) : len_cnt_q;

	always_comb begin
		st_d = st_q; item_d = item_q; res_d = res_q;
		run_active_d = run_active_q; run_pub_d = run_pub_q; full_d = full_q;
		len_cnt_d = len_cnt_q; commit_len_d = commit_len_q;
		scan_rank_d = scan_rank_q; removed_d = removed_q;
		cmd.op = OP_NONE;
		cmd.char_code = item_q.char_code;
		cmd.conn_id = item_q.conn_id;
		cmd.scan_hit = chain[MAX_SUBS].sel_hit;
		cmd_len = commit_len_q;
		cmd_rank = scan_rank_q;
		load = 1'b0;
		load_data = res_q;
		unique case (st_q)
			S_IDLE: begin
				if (item_valid) begin
					item_d = item;
					st_d = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (item_q.mode)
					MODE_NONE: st_d = S_IDLE;
					MODE_CLOSE: begin
						// drop any open run, mark the victims, renumber from the top rank down
						run_active_d = 1'b0;
						len_cnt_d = '0;
						cmd.op = OP_CLOSE_MARK;
						scan_rank_d = RW'(MAX_SUBS - 1);
						removed_d = '0;
						st_d = S_CLOSE_SCAN;
					end
					MODE_SUB, MODE_PUB: begin
						if (item_q.empty_text) begin
							run_active_d = 1'b0;
							len_cnt_d = '0;
							if (is_pub) begin
								cmd.op = OP_CLR;
								st_d = S_FIN_GO;
							end else begin
								cmd.op = OP_SUB_START;
								if (table_full) begin
									res_d = mk_res(K_FULL, item_q.conn_id, 5'd0, 1'b1);
									st_d = S_EMIT;
								end else begin
									commit_len_d = '0;
									st_d = S_COMMIT;
								end
							end
						end else begin
							if (!run_active_q || run_pub_q != is_pub) begin
								// open a new run; a run of the other kind is dropped
								run_active_d = 1'b1;
								run_pub_d = is_pub;
								len_cnt_d = '0;
								if (is_pub) begin
									cmd.op = OP_CLR;
								end else begin
									cmd.op = OP_SUB_START;
									full_d = table_full;
								end
							end
							st_d = is_pub ? S_FEED_GO : S_SUB_CHAR;
						end
					end
				endcase
			end
			S_SUB_CHAR: begin
				if (!full_q && len_cnt_q < LCW'(MAX_FILTER_LEN)) begin
					cmd.op = OP_WRITE;
					cmd_len = LW'(len_cnt_q);
				end
				len_cnt_d = len_next;
				if (item_q.last_char) begin
					run_active_d = 1'b0;
					len_cnt_d = '0;
					if (full_q) begin
						res_d = mk_res(K_FULL, item_q.conn_id, 5'd0, 1'b1);
						st_d = S_EMIT;
					end else if (len_next > LCW'(MAX_FILTER_LEN)) begin
						res_d = mk_res(K_TOO_LONG, item_q.conn_id, 5'd0, 1'b1);
						st_d = S_EMIT;
					end else begin
						commit_len_d = LW'(len_next);
						st_d = S_COMMIT;
					end
				end else begin
					st_d = S_IDLE;
				end
			end
			S_COMMIT: begin
				cmd.op = OP_COMMIT;
				res_d = mk_res(K_SUBSCRIBED, item_q.conn_id, 5'd0, 1'b1);
				st_d = S_EMIT;
			end
			S_FEED_GO: begin
				cmd.op = OP_FEED;
				st_d = S_FEED_WAIT;
			end
			S_FEED_WAIT: begin
				// hold until every cell has settled on this character
				if (!busy) begin
					if (item_q.last_char) begin
						run_active_d = 1'b0;
						st_d = S_FIN_GO;
					end else begin
						st_d = S_IDLE;
					end
				end
			end
			S_FIN_GO: begin
				cmd.op = OP_FIN;
				st_d = S_FIN_WAIT;
			end
			S_FIN_WAIT: begin
				if (!busy) begin
					scan_rank_d = '0;
					st_d = S_SCAN;
				end
			end
			S_SCAN: begin
				// walk ranks newest first; stall on a hit while the output is full
				cmd.op = OP_SCAN;
				if (!chain[MAX_SUBS].sel_hit || out_free) begin
					if (chain[MAX_SUBS].sel_hit) begin
						load = 1'b1;
						load_data = mk_res(K_DELIVER, chain[MAX_SUBS].sel_owner, 5'd0, 1'b0);
					end
					if (scan_rank_q == RW'(MAX_SUBS - 1)) begin
						res_d = mk_res(K_PUB_DONE, item_q.conn_id, 5'd0, 1'b1);
						st_d = S_EMIT;
					end else begin
						scan_rank_d = scan_rank_q + RW'(1);
					end
				end
			end
			S_CLOSE_SCAN: begin
				cmd.op = OP_CLOSE_STEP;
				if (chain[MAX_SUBS].sel_hit) begin
					removed_d = removed_q + CW'(1);
				end
				if (scan_rank_q == '0) begin
					res_d = mk_res(K_CLOSE_DONE, item_q.conn_id, 5'(removed_d), 1'b1);
					st_d = S_EMIT;
				end else begin
					scan_rank_d = scan_rank_q - RW'(1);
				end
			end
			S_EMIT: begin
				if (out_free) begin
					load = 1'b1;
					load_data = res_q;
					st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			run_active_q <= 1'b0;
			run_pub_q <= 1'b0;
			full_q <= 1'b0;
			len_cnt_q <= '0;
			scan_rank_q <= '0;
			removed_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			run_active_q <= run_active_d;
			run_pub_q <= run_pub_d;
			full_q <= full_d;
			len_cnt_q <= len_cnt_d;
			scan_rank_q <= scan_rank_d;
			removed_q <= removed_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		item_q <= item_d;
		res_q <= res_d;
		commit_len_q <= commit_len_d;
		if (load) begin
			out_q <= load_data;
		end
	end

	assign result_valid = out_valid_q;
	assign result = out_q;

	a_idle_cells_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_IDLE |-> !busy)
		else $error("cell still busy while idle");

	a_deliver_not_final: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !(load_data.kind == K_DELIVER && load_data.final_result))
		else $error("delivery marked final");

	a_removed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		removed_q <= CW'(MAX_SUBS))
		else $error("removed count exceeds table size");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> out_free)
		else $error("output register overwritten");

endmodule
